// ----- rtl/blpm_pkg.sv -----
// shared types and constants for the binary trie longest prefix match unit
// node entry layout, memory request bundle, result bundle and walker state codes
// no dependencies
`timescale 1ns / 1ps

package blpm_pkg;

  localparam int NODES    = 4096;
  localparam int NODE_W   = $clog2(NODES);
  localparam int FREE_W   = NODE_W + 1;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 40;

  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(ADDR_W);
  localparam logic [FREE_W-1:0] POOL_END   = FREE_W'(NODES);
  localparam logic [FREE_W-1:0] FIRST_FREE = FREE_W'(1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] zero_child;
    logic [NODE_W-1:0] one_child;
    logic              marked;
    logic [ADDR_W-1:0] stored_prefix;
    logic [LEN_W-1:0]  stored_len;
  } node_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    node_t             wr_data;
  } mem_req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] matched_prefix;
    logic [LEN_W-1:0]  matched_len;
    logic              error;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FRESH = 3'b100
  } walk_state_t;

endpackage

// ----- rtl/blpm_node_store.sv -----
// trie node storage: synchronous node memory plus the root entry in flip-flops
// depends on blpm_pkg
`timescale 1ns / 1ps

module blpm_node_store (
  input  logic                     clk,
  input  logic                     rst,
  input  blpm_pkg::mem_req_t       req,
  input  logic [blpm_pkg::NODE_W-1:0] cur_node,
  output blpm_pkg::node_t          entry
);
  import blpm_pkg::*;

  node_t mem [NODES];
  node_t rd_q;

  logic              root_marked;
  logic [NODE_W-1:0] root_zero;
  logic [NODE_W-1:0] root_one;
  logic [ADDR_W-1:0] root_prefix;
  logic [LEN_W-1:0]  root_len;

  // entry 0 of the array is never written or read, the root lives in registers
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr != '0)) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_marked <= 1'b0;
      root_zero   <= '0;
      root_one    <= '0;
    end else if (req.wr_en && (req.wr_addr == '0)) begin
      root_marked <= req.wr_data.marked;
      root_zero   <= req.wr_data.zero_child;
      root_one    <= req.wr_data.one_child;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == '0)) begin
      root_prefix <= req.wr_data.stored_prefix;
      root_len    <= req.wr_data.stored_len;
    end
  end

  always_comb begin
    if (cur_node == '0) begin
      entry.zero_child    = root_zero;
      entry.one_child     = root_one;
      entry.marked        = root_marked;
      entry.stored_prefix = root_prefix;
      entry.stored_len    = root_len;
    end else begin
      entry = rd_q;
    end
  end

endmodule

// ----- rtl/blpm_walker.sv -----
// trie walk sequencer: one trie level per cycle for insert and lookup,
// node allocation from a bump counter, read-modify-write of node entries
// depends on blpm_pkg
`timescale 1ns / 1ps

module blpm_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [blpm_pkg::ADDR_W-1:0] in_addr,
  input  logic [blpm_pkg::LEN_W-1:0]  in_len,
  input  logic                        out_free,
  output logic                        res_valid,
  output blpm_pkg::result_t           res,
  output blpm_pkg::mem_req_t          req,
  output logic [blpm_pkg::NODE_W-1:0] cur_node,
  input  blpm_pkg::node_t             entry
);
  import blpm_pkg::*;

  walk_state_t state, state_next;

  logic              cmd;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_sh;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  level;
  logic [NODE_W-1:0] node;
  logic [FREE_W-1:0] next_free;
  logic              found;
  logic [ADDR_W-1:0] best_prefix;
  logic [LEN_W-1:0]  best_len;

  logic              advance;
  logic              alloc;
  logic [NODE_W-1:0] advance_node;
  logic              finish;

  logic              done_lvl;
  logic [NODE_W-1:0] slot;
  logic              pool_full;
  logic              cur_found;
  logic [ADDR_W-1:0] cur_prefix;
  logic [LEN_W-1:0]  cur_len;
  logic [NODE_W-1:0] fresh_idx;
  logic              accept;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cur_node  = node;
  assign done_lvl  = (level > len);
  assign slot      = addr_sh[ADDR_W-1] ? entry.one_child : entry.zero_child;
  assign pool_full = (next_free == POOL_END);
  assign fresh_idx = next_free[NODE_W-1:0];
  assign cur_found  = found | entry.marked;
  assign cur_prefix = entry.marked ? entry.stored_prefix : best_prefix;
  assign cur_len    = entry.marked ? entry.stored_len : best_len;

  always_comb begin
    state_next   = state;
    req          = '0;
    advance      = 1'b0;
    alloc        = 1'b0;
    advance_node = slot;
    finish       = 1'b0;
    res          = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (cmd == CMD_LOOKUP) begin
          if (done_lvl || (slot == '0)) begin
            finish             = 1'b1;
            res.found          = cur_found;
            res.matched_prefix = cur_prefix;
            res.matched_len    = cur_len;
          end else begin
            advance     = 1'b1;
            req.rd_en   = 1'b1;
            req.rd_addr = slot;
          end
        end else if (done_lvl) begin
          finish                      = 1'b1;
          req.wr_en                   = out_free;
          req.wr_addr                 = node;
          req.wr_data                 = entry;
          req.wr_data.marked          = 1'b1;
          req.wr_data.stored_prefix   = addr;
          req.wr_data.stored_len      = len;
        end else if (slot != '0) begin
          advance     = 1'b1;
          req.rd_en   = 1'b1;
          req.rd_addr = slot;
        end else if (pool_full) begin
          finish    = 1'b1;
          res.error = 1'b1;
        end else begin
          // missing child: hook a fresh node into the parent, walk on without reads
          advance      = 1'b1;
          alloc        = 1'b1;
          advance_node = fresh_idx;
          req.wr_en    = 1'b1;
          req.wr_addr  = node;
          req.wr_data  = entry;
          if (addr_sh[ADDR_W-1]) begin
            req.wr_data.one_child = fresh_idx;
          end else begin
            req.wr_data.zero_child = fresh_idx;
          end
          state_next = S_FRESH;
        end
      end
      S_FRESH: begin
        // current node is newly allocated and not yet written
        req.wr_addr = node;
        if (done_lvl) begin
          finish                    = 1'b1;
          req.wr_en                 = out_free;
          req.wr_data.marked        = 1'b1;
          req.wr_data.stored_prefix = addr;
          req.wr_data.stored_len    = len;
        end else if (pool_full) begin
          finish    = 1'b1;
          res.error = 1'b1;
          req.wr_en = out_free;
        end else begin
          advance      = 1'b1;
          alloc        = 1'b1;
          advance_node = fresh_idx;
          req.wr_en    = 1'b1;
          if (addr_sh[ADDR_W-1]) begin
            req.wr_data.one_child = fresh_idx;
          end else begin
            req.wr_data.zero_child = fresh_idx;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish && out_free) begin
      state_next = S_IDLE;
    end
  end

  assign res_valid = finish && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= FIRST_FREE;
    end else begin
      state <= state_next;
      if (alloc) begin
        next_free <= next_free + FIRST_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd         <= in_cmd;
      addr        <= in_addr;
      addr_sh     <= in_addr;
      len         <= (in_len > MAX_LEN) ? MAX_LEN : in_len;
      level       <= LEN_W'(1);
      node        <= '0;
      found       <= 1'b0;
      best_prefix <= '0;
      best_len    <= '0;
    end else if (advance) begin
      addr_sh     <= {addr_sh[ADDR_W-2:0], 1'b0};
      level       <= level + LEN_W'(1);
      node        <= advance_node;
      found       <= cur_found;
      best_prefix <= cur_prefix;
      best_len    <= cur_len;
    end
  end

endmodule

// ----- rtl/binary_trie_longest_prefix_match_unit.sv -----
// len saturated at 32; a new transaction is taken only in idle, once the previous result is issued
// throughput: one trie level per cycle while walking, bound by the node memory read whose data
//   feeds the next level address; the walk holds its last level while the output is full
// reset: sync active high; root mark and children cleared and allocator set to node 1, no clearing pass
// depends on blpm_pkg, blpm_node_store, blpm_walker
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [blpm_pkg::IN_DW-1:0]  s_tdata,   // address, prefix_len, zero pad
  input  logic                        s_tuser,   // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [blpm_pkg::OUT_DW-1:0] m_tdata    // found, matched_prefix, matched_len, error
);
  import blpm_pkg::*;

  mem_req_t          req;
  node_t             entry;
  logic [NODE_W-1:0] cur_node;
  logic              res_valid;
  result_t           res;
  result_t           out_q;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  blpm_node_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cur_node (cur_node),
    .entry    (entry)
  );

  blpm_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_addr   (s_tdata[ADDR_W-1:0]),
    .in_len    (s_tdata[ADDR_W+LEN_W-1:ADDR_W]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .req       (req),
    .cur_node  (cur_node),
    .entry     (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {out_q.error, out_q.matched_len, out_q.matched_prefix, out_q.found};

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for binary_trie_longest_prefix_match_unit
// holds a trie predictor in a scoreboard class, drives both stream sides with random idling
// depends on blpm_pkg and the rtl of the unit
`timescale 1ns / 1ps

class trie_route_scoreboard;
  // predictor copy of the node memory
  bit [blpm_pkg::NODE_W-1:0] zero_kid [blpm_pkg::NODES];
  bit [blpm_pkg::NODE_W-1:0] one_kid [blpm_pkg::NODES];
  bit                        is_marked [blpm_pkg::NODES];
  bit [blpm_pkg::ADDR_W-1:0] route_addr [blpm_pkg::NODES];
  bit [blpm_pkg::LEN_W-1:0]  route_len [blpm_pkg::NODES];
  int                        next_node;
  blpm_pkg::result_t         pending_results[$];
  int                        failures;

  function new();
    next_node = 1;
    failures  = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // works out the result of one accepted request and queues it
  function void note_request(logic cmd, logic [31:0] addr, logic [5:0] len);
    int depth;
    bit [blpm_pkg::NODE_W-1:0] node;
    int lvl;
    bit [blpm_pkg::NODE_W-1:0] kid;
    bit starved;
    bit walking;
    blpm_pkg::result_t r;
    depth   = (len > blpm_pkg::ADDR_W) ? blpm_pkg::ADDR_W : int'(len);
    r       = '0;
    node    = '0;
    starved = 1'b0;
    if (cmd == blpm_pkg::CMD_INSERT) begin
      for (lvl = 1; lvl <= depth && !starved; lvl++) begin
        kid = addr[32-lvl] ? one_kid[node] : zero_kid[node];
        if (kid == '0) begin
          if (next_node >= blpm_pkg::NODES) begin
            starved = 1'b1;
          end else begin
            kid = next_node[blpm_pkg::NODE_W-1:0];
            next_node++;
            zero_kid[kid]   = '0;
            one_kid[kid]    = '0;
            is_marked[kid]  = 1'b0;
            route_addr[kid] = '0;
            route_len[kid]  = '0;
            if (addr[32-lvl]) one_kid[node] = kid;
            else zero_kid[node] = kid;
          end
        end
        if (!starved) node = kid;
      end
      if (starved) begin
        r.error = 1'b1;
      end else begin
        is_marked[node]  = 1'b1;
        route_addr[node] = addr;
        route_len[node]  = depth[blpm_pkg::LEN_W-1:0];
      end
    end else begin
      lvl     = 1;
      walking = 1'b1;
      while (walking) begin
        if (is_marked[node]) begin
          r.found          = 1'b1;
          r.matched_prefix = route_addr[node];
          r.matched_len    = route_len[node];
        end
        if (lvl > depth) begin
          walking = 1'b0;
        end else begin
          kid = addr[32-lvl] ? one_kid[node] : zero_kid[node];
          if (kid == '0) begin
            walking = 1'b0;
          end else begin
            node = kid;
            lvl++;
          end
        end
      end
    end
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      failures++;
    end
  endfunction

  // result fields from the lowest bit up: found, matched_prefix, matched_len, error
  function void check_result(logic [blpm_pkg::OUT_DW-1:0] beat);
    blpm_pkg::result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, beat);
      failures++;
    end else begin
      e = pending_results.pop_front();
      compare_field("found", 32'(e.found), 32'(beat[0]));
      compare_field("matched_prefix", e.matched_prefix, beat[32:1]);
      compare_field("matched_len", 32'(e.matched_len), 32'(beat[38:33]));
      compare_field("error", 32'(e.error), 32'(beat[39]));
    end
  endfunction
endclass

module tb;
  import blpm_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int STALL_LIMIT  = 2000;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata  = '0;
  logic              s_tuser  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;

  bit                idle_en = 1'b1;
  int                quiet_cycles = 0;
  logic [31:0]       route_pool[$];

  trie_route_scoreboard sb = new();

  binary_trie_longest_prefix_match_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // request side monitor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.note_request(s_tuser, s_tdata[31:0], s_tdata[37:32]);
    end
  end

  // result sink with random back-pressure, checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= idle_en ? ($urandom_range(0, 99) >= 29) : 1'b1;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one request transaction; called and returns at a rising edge
  task automatic send_item(input logic cmd, input logic [31:0] addr, input logic [5:0] len);
    while (idle_en && $urandom_range(0, 99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, len, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    int          i;
    int          roll;
    int          sub;
    logic [31:0] addr;
    logic [5:0]  len;
    logic        cmd;
    logic [31:0] base;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty trie, root prefix, saturation, overwrite, early stop
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd32);
    send_item(CMD_LOOKUP, 32'h0000_0000, 6'd0);
    send_item(CMD_INSERT, 32'h1234_5678, 6'd0);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_item(CMD_LOOKUP, 32'h0000_0000, 6'd63);
    send_item(CMD_INSERT, 32'h0000_0000, 6'd32);
    send_item(CMD_LOOKUP, 32'h0000_0000, 6'd32);
    send_item(CMD_LOOKUP, 32'h0000_0000, 6'd31);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd33);
    send_item(CMD_INSERT, 32'h0A12_3456, 6'd8);
    send_item(CMD_LOOKUP, 32'h0AFF_FFFF, 6'd32);
    send_item(CMD_INSERT, 32'h0A65_4321, 6'd8);
    send_item(CMD_LOOKUP, 32'h0A00_0001, 6'd24);
    send_item(CMD_INSERT, 32'h0A0B_0000, 6'd16);
    send_item(CMD_LOOKUP, 32'h0A0B_FFFF, 6'd32);
    send_item(CMD_LOOKUP, 32'h0A0B_FFFF, 6'd12);
    send_item(CMD_LOOKUP, 32'h0B00_0000, 6'd32);
    send_item(CMD_INSERT, 32'h8000_0000, 6'd1);
    send_item(CMD_LOOKUP, 32'hC000_0000, 6'd32);
    send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 6'd32);

    // random: lookups mostly near stored routes, long inserts later drain the pool
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en = !(i >= 500 && i < 800);
      roll = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      base = (route_pool.size() > 0) ? route_pool[$urandom_range(0, route_pool.size() - 1)]
                                     : $urandom;
      if (roll < 45) begin
        cmd = CMD_INSERT;
        if (i >= 1000 && sub < 50) begin
          addr = $urandom;
          len  = 6'($urandom_range(32, 63));
        end else if (sub < 80) begin
          addr = base ^ ($urandom >> $urandom_range(0, 31));
          len  = 6'($urandom_range(0, 40));
        end else begin
          addr = $urandom;
          len  = 6'($urandom_range(0, 12));
        end
        if (route_pool.size() < 512) route_pool.push_back(addr);
        else route_pool[$urandom_range(0, 511)] = addr;
      end else begin
        cmd = CMD_LOOKUP;
        addr = (sub < 75) ? (base ^ ($urandom >> $urandom_range(1, 32))) : $urandom;
        len  = ($urandom_range(0, 99) < 60) ? 6'd32 : 6'($urandom_range(0, 63));
      end
      send_item(cmd, addr, len);
    end
    s_tvalid <= 1'b0;
    idle_en = 1'b1;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
